>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int SCROLL_CELLS = CELLS - COLUMNS;

  // Widths
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CUR_W    = $clog2(CELLS + 1);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Cell contents
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

  // Configuration register indexes
  localparam logic CFG_TEXT_ATTR  = 1'b0;
  localparam logic CFG_BLANK_ATTR = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_PUT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic                load;
    logic [CURSOR_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attribute;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> rtl/core/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console over an 80x25 screen store.
//
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   in_tdata: opcode, char_code, cell_index
//  out_     master     out_tvalid/out_tready out_tdata: cursor_cell, read_char,
//                                            read_attribute
//  cfg_     write      cfg_wen               cfg_index, cfg_wdata
//
// Put char, newline, backspace, out-of-range reads and unused opcodes load
// their result in the accepting cycle; an in-range cell read loads it from
// ST_READ, after the registered store read. Clear blanks every cell through
// the single write port; put char with a scroll pending copies the rows up,
// blanks the bottom row, then writes the character in ST_PUT.
// After reset a clearing pass fills the store; no transaction is accepted
// meanwhile, configuration writes are taken.
// The output register holds a finished result while the sequencer returns to
// idle; a new item is taken only when that register is empty or being drained.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] opcode, [10:3] char_code, [21:11] cell_index, [23:22] zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [10:0] cursor_cell, [18:11] read_char, [26:19] read_attribute, [31:27] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wen,
  input  logic                            cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);

  logic [tcw_pkg::ATTR_W-1:0]  text_attr_r;
  logic [tcw_pkg::ATTR_W-1:0]  blank_attr_r;
  logic                        out_valid_r;
  logic [tcw_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                        out_free;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
  tcw_pkg::item_t              in_item;
  tcw_pkg::ram_req_t           ram_req;
  tcw_pkg::result_t            res;

  // Unpack input transaction
  assign in_item.opcode     = in_tdata[2:0];
  assign in_item.char_code  = in_tdata[10:3];
  assign in_item.cell_index = in_tdata[21:11];

  assign out_free = !out_valid_r || out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r  <= tcw_pkg::RESET_ATTR;
      blank_attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wen) begin
      case (cfg_index)
        tcw_pkg::CFG_TEXT_ATTR:  text_attr_r  <= cfg_wdata;
        tcw_pkg::CFG_BLANK_ATTR: blank_attr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .out_free   (out_free),
    .text_attr  (text_attr_r),
    .blank_attr (blank_attr_r),
    .ram_rdata  (ram_rdata),
    .in_ready   (in_tready),
    .ram_req    (ram_req),
    .res        (res)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data_r <= {5'd0, res.read_attribute, res.read_char, res.cursor_cell};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tcw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer: cursor tracking, one sweep counter shared by the clearing pass,
// scroll copy, row blanking and screen clear, and screen store access.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tcw_pkg::item_t              in_item,
  input  logic                        out_free,
  input  logic [tcw_pkg::ATTR_W-1:0]  text_attr,
  input  logic [tcw_pkg::ATTR_W-1:0]  blank_attr,
  input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata,
  output logic                        in_ready,
  output tcw_pkg::ram_req_t           ram_req,
  output tcw_pkg::result_t            res
);

  tcw_pkg::state_t                   state_r, state_nxt;
  logic [tcw_pkg::ADDR_W-1:0]        cnt_r, cnt_nxt;
  logic [tcw_pkg::CUR_W-1:0]         cursor_r, cursor_nxt;
  logic [tcw_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [tcw_pkg::CHAR_W-1:0]        char_r, char_nxt;
  logic                              scroll_r, scroll_nxt;

  tcw_pkg::op_t                      op;
  logic                              accept;
  logic                              past_end;
  logic                              idx_ok;
  logic                              sweep_last;

  assign op         = tcw_pkg::op_t'(in_item.opcode);
  assign in_ready   = (state_r == tcw_pkg::ST_IDLE) && out_free;
  assign accept     = in_valid && in_ready;
  assign past_end   = (cursor_r == tcw_pkg::CUR_W'(tcw_pkg::CELLS));
  assign idx_ok     = (32'(in_item.cell_index) < 32'(tcw_pkg::CELLS));
  assign sweep_last = (cnt_r == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (sweep_last) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            tcw_pkg::OP_PUT:   if (past_end) state_nxt = tcw_pkg::ST_SCROLL;
            tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_BLANK;
            tcw_pkg::OP_READ:  if (idx_ok) state_nxt = tcw_pkg::ST_READ;
            default:           state_nxt = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt_r == tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS)) state_nxt = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (sweep_last) state_nxt = scroll_r ? tcw_pkg::ST_PUT : tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_PUT:  state_nxt = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_IDLE;
      default:          state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // Outputs, store access and cursor update
  always_comb begin
    cnt_nxt    = cnt_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    char_nxt   = char_r;
    scroll_nxt = scroll_r;
    ram_req    = '0;
    res        = '0;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
        cnt_nxt       = sweep_last ? '0 : cnt_r + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          res.load = 1'b1;
          case (op)
            tcw_pkg::OP_PUT: begin
              if (past_end) begin
                // Scroll first; the character lands at the bottom row start
                res.load   = 1'b0;
                char_nxt   = in_item.char_code;
                cursor_nxt = tcw_pkg::CUR_W'(tcw_pkg::SCROLL_CELLS + 1);
                col_nxt    = tcw_pkg::COL_W'(1);
                cnt_nxt    = '0;
                scroll_nxt = 1'b1;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tcw_pkg::ADDR_W'(cursor_r);
                ram_req.wdata = {text_attr, in_item.char_code};
                cursor_nxt    = cursor_r + 1'b1;
                col_nxt       = (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ?
                                '0 : col_r + 1'b1;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              if (!past_end) begin
                cursor_nxt = cursor_r - tcw_pkg::CUR_W'(col_r)
                           + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
                col_nxt    = '0;
              end
            end
            tcw_pkg::OP_BACKSPACE: begin
              if (cursor_r != '0) begin
                cursor_nxt    = cursor_r - 1'b1;
                col_nxt       = (col_r == '0) ?
                                tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col_r - 1'b1;
                ram_req.we    = 1'b1;
                ram_req.waddr = tcw_pkg::ADDR_W'(cursor_r - 1'b1);
                ram_req.wdata = {blank_attr, tcw_pkg::SPACE_CHAR};
              end
            end
            tcw_pkg::OP_CLEAR: begin
              res.load   = 1'b0;
              cursor_nxt = '0;
              col_nxt    = '0;
              cnt_nxt    = '0;
              scroll_nxt = 1'b0;
            end
            tcw_pkg::OP_READ: begin
              if (idx_ok) begin
                res.load      = 1'b0;
                ram_req.re    = 1'b1;
                ram_req.raddr = tcw_pkg::ADDR_W'(in_item.cell_index);
              end
            end
            default: ;
          endcase
          res.cursor_cell = tcw_pkg::CURSOR_W'(cursor_nxt);
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Read one row ahead, write the cell read in the previous cycle
        ram_req.re    = (cnt_r != tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS));
        ram_req.raddr = cnt_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        ram_req.we    = (cnt_r != '0);
        ram_req.waddr = cnt_r - 1'b1;
        ram_req.wdata = ram_rdata;
        if (cnt_r != tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS)) cnt_nxt = cnt_r + 1'b1;
      end
      tcw_pkg::ST_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = {blank_attr, tcw_pkg::SPACE_CHAR};
        cnt_nxt       = sweep_last ? '0 : cnt_r + 1'b1;
        if (sweep_last && !scroll_r) begin
          res.load        = 1'b1;
          res.cursor_cell = tcw_pkg::CURSOR_W'(cursor_r);
        end
      end
      tcw_pkg::ST_PUT: begin
        ram_req.we      = 1'b1;
        ram_req.waddr   = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS);
        ram_req.wdata   = {text_attr, char_r};
        scroll_nxt      = 1'b0;
        res.load        = 1'b1;
        res.cursor_cell = tcw_pkg::CURSOR_W'(cursor_r);
      end
      tcw_pkg::ST_READ: begin
        res.load           = 1'b1;
        res.cursor_cell    = tcw_pkg::CURSOR_W'(cursor_r);
        res.read_char      = ram_rdata[tcw_pkg::CHAR_W-1:0];
        res.read_attribute = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tcw_pkg::ST_INIT;
      cnt_r    <= '0;
      cursor_r <= '0;
      col_r    <= '0;
      scroll_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      scroll_r <= scroll_nxt;
    end
  end

  // Held character for the write after a scroll
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= tcw_pkg::CUR_W'(tcw_pkg::CELLS))
    else $error("cursor beyond past-end position");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    else $error("column counter out of range");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |=> state_r == tcw_pkg::ST_IDLE)
    else $error("result issued while work remains");

  a_put_after_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_PUT) |-> $past(state_r) == tcw_pkg::ST_BLANK)
    else $error("deferred write without a preceding row blank");

endmodule

>>> tb/sv/console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_checker
// Watches the item, result and register ports of the text console writer,
// keeps its own copy of the screen, cursor and attributes, predicts the
// report of every accepted item and compares each returned report field by
// field in order. Hands the count of open reports and of faults to the top.
// ----------------------------------------------------------------------------
module console_checker
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // [2:0] opcode, [10:3] char_code, [21:11] cell_index, [23:22] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [10:0] cursor_cell, [18:11] read_char, [26:19] read_attribute, [31:27] zero
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wen,
  input  logic                  cfg_index,
  input  logic [ATTR_W-1:0]     cfg_wdata,
  output int                    pending_reports,
  output int                    mismatch_count
);

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attribute;
  } console_report_t;

  // Shadow screen, cursor and attribute registers
  logic [CHAR_W-1:0] screen_chars [CELLS];
  logic [ATTR_W-1:0] screen_attrs [CELLS];
  int unsigned       cursor_pos;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] blank_attr;

  console_report_t expected_reports [$];
  int              report_seq = 0;
  int              backlog = 0;
  int              fault_total = 0;

  assign pending_reports = backlog;
  assign mismatch_count  = fault_total;

  // Print one line per fault and count it
  task automatic report_fault(input string msg);
    $display("console_checker: report %0d: %s", report_seq, msg);
    fault_total++;
  endtask

  task automatic blank_cell(input int unsigned pos);
    screen_chars[pos] = SPACE_CHAR;
    screen_attrs[pos] = blank_attr;
  endtask

  // Apply one console operation to the shadow screen and build its report
  task automatic apply_console_op(
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] ch,
    input  logic [IDX_W-1:0]  idx,
    output console_report_t   rpt
  );
    int unsigned i;
    rpt = '0;
    case (op)
      OP_PUT: begin
        // Scroll up one row first when the cursor sits past the end
        if (cursor_pos >= CELLS) begin
          for (i = 0; i < SCROLL_CELLS; i++) begin
            screen_chars[i] = screen_chars[i + COLUMNS];
            screen_attrs[i] = screen_attrs[i + COLUMNS];
          end
          for (i = SCROLL_CELLS; i < CELLS; i++) blank_cell(i);
          cursor_pos = SCROLL_CELLS;
        end
        screen_chars[cursor_pos] = ch;
        screen_attrs[cursor_pos] = text_attr;
        cursor_pos++;
      end
      OP_NEWLINE: begin
        // Past the end stays past the end
        if (cursor_pos < CELLS) cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
      end
      OP_BACKSPACE: begin
        if (cursor_pos != 0) begin
          cursor_pos--;
          blank_cell(cursor_pos);
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) blank_cell(i);
        cursor_pos = 0;
      end
      OP_READ: begin
        if (idx < CELLS) begin
          rpt.read_char      = screen_chars[idx];
          rpt.read_attribute = screen_attrs[idx];
        end
      end
      default: ;
    endcase
    rpt.cursor_cell = cursor_pos[CURSOR_W-1:0];
  endtask

  // Predict on accepted items, compare on accepted results, track registers
  always @(posedge clk) begin
    console_report_t rpt;
    console_report_t seen;
    int k;
    if (!rst_n) begin
      for (k = 0; k < CELLS; k++) begin
        screen_chars[k] = SPACE_CHAR;
        screen_attrs[k] = RESET_ATTR;
      end
      cursor_pos = 0;
      text_attr  = RESET_ATTR;
      blank_attr = RESET_ATTR;
      expected_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_console_op(in_tdata[2:0], in_tdata[10:3], in_tdata[21:11], rpt);
        expected_reports.push_back(rpt);
      end
      if (out_tvalid && out_tready) begin
        report_seq++;
        seen.cursor_cell    = out_tdata[10:0];
        seen.read_char      = out_tdata[18:11];
        seen.read_attribute = out_tdata[26:19];
        if (expected_reports.size() == 0) begin
          report_fault($sformatf("unexpected transaction, cursor %0d", seen.cursor_cell));
        end else begin
          rpt = expected_reports.pop_front();
          if (seen.cursor_cell != rpt.cursor_cell)
            report_fault($sformatf("cursor_cell %0d, want %0d",
                                   seen.cursor_cell, rpt.cursor_cell));
          if (seen.read_char != rpt.read_char)
            report_fault($sformatf("read_char 0x%02h, want 0x%02h",
                                   seen.read_char, rpt.read_char));
          if (seen.read_attribute != rpt.read_attribute)
            report_fault($sformatf("read_attribute 0x%02h, want 0x%02h",
                                   seen.read_attribute, rpt.read_attribute));
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          CFG_TEXT_ATTR:  text_attr  = cfg_wdata;
          CFG_BLANK_ATTR: blank_attr = cfg_wdata;
          default: ;
        endcase
      end
    end
    backlog <= expected_reports.size();
  end

endmodule

>>> tb/sv/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Drives the text console writer with a short directed pass and then random
// runs of text lines, reads, walks to the bottom row with scrolling, clears
// and opcode noise, under several attribute settings and random idling on
// both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 20;

  // Opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wen   = 1'b0;
  logic                  cfg_index = CFG_TEXT_ATTR;
  logic [ATTR_W-1:0]     cfg_wdata = '0;

  int pending_reports;
  int mismatch_count;
  int cycle_count = 0;
  int items_sent  = 0;
  int gap_pct     = 25;
  int stall_pct   = 25;

  text_console_writer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  console_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending_reports (pending_reports),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_console_writer_unit: done, errors");
      $finish;
    end
  end

  // Stall the result side in random bursts
  initial begin
    int hold;
    forever begin
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        hold = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold = $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
    end
  end

  // Send one item; hold valid until the transaction completes
  task automatic push_console_op(
    input logic [OP_W-1:0]   op,
    input logic [CHAR_W-1:0] ch,
    input logic [IDX_W-1:0]  idx
  );
    int gap;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, ch, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every report has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
  endtask

  task automatic write_attributes(input logic [ATTR_W-1:0] text_a,
                                  input logic [ATTR_W-1:0] blank_a);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_TEXT_ATTR;
    cfg_wdata <= text_a;
    @(posedge clk);
    cfg_index <= CFG_BLANK_ATTR;
    cfg_wdata <= blank_a;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Favor cells near row starts, where text lines land
  function automatic logic [IDX_W-1:0] pick_read_index();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55)
      return IDX_W'($urandom_range(ROWS - 1) * COLUMNS + $urandom_range(24));
    if (roll < 85) return IDX_W'($urandom_range(CELLS - 1));
    return IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
  endfunction

  // One random run of related operations
  task automatic run_segment();
    int                kind;
    int                n;
    int                k;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // Text line with the odd correction
      n = $urandom_range(1, COLUMNS + 10);
      for (k = 0; k < n; k++) begin
        ch = CHAR_W'(($urandom_range(99) < 80) ? $urandom_range(32, 126)
                                                : $urandom_range(255));
        if ($urandom_range(99) < 6)
          push_console_op(OP_BACKSPACE, ch, IDX_W'($urandom_range(2 ** IDX_W - 1)));
        else
          push_console_op(OP_PUT, ch, IDX_W'($urandom_range(2 ** IDX_W - 1)));
      end
      if ($urandom_range(1))
        push_console_op(OP_NEWLINE, CHAR_W'($urandom_range(255)),
                        IDX_W'($urandom_range(2 ** IDX_W - 1)));
    end else if (kind < 55) begin
      n = $urandom_range(1, 8);
      repeat (n) push_console_op(OP_READ, CHAR_W'($urandom_range(255)), pick_read_index());
    end else if (kind < 70) begin
      // Walk off the last row, then exercise the past-end cases and scroll
      repeat (ROWS + 1)
        push_console_op(OP_NEWLINE, CHAR_W'($urandom_range(255)),
                        IDX_W'($urandom_range(2 ** IDX_W - 1)));
      push_console_op(OP_BACKSPACE, CHAR_W'($urandom_range(255)),
                      IDX_W'($urandom_range(2 ** IDX_W - 1)));
      push_console_op(OP_PUT, CHAR_W'($urandom_range(32, 126)),
                      IDX_W'($urandom_range(2 ** IDX_W - 1)));
      push_console_op(OP_PUT, CHAR_W'($urandom_range(255)),
                      IDX_W'($urandom_range(2 ** IDX_W - 1)));
      n = $urandom_range(5);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(3))
          0:       push_console_op(OP_PUT, CHAR_W'($urandom_range(255)), pick_read_index());
          1:       push_console_op(OP_NEWLINE, CHAR_W'($urandom_range(255)),
                                   pick_read_index());
          2:       push_console_op(OP_BACKSPACE, CHAR_W'($urandom_range(255)),
                                   pick_read_index());
          default: push_console_op(OP_READ, CHAR_W'($urandom_range(255)),
                                   IDX_W'(SCROLL_CELLS - COLUMNS +
                                          $urandom_range(2 * COLUMNS - 1)));
        endcase
      end
    end else if (kind < 72) begin
      push_console_op(OP_CLEAR, CHAR_W'($urandom_range(255)),
                      IDX_W'($urandom_range(2 ** IDX_W - 1)));
    end else begin
      // Noise over every opcode and full field ranges
      n = $urandom_range(1, 10);
      repeat (n)
        push_console_op(OP_W'($urandom_range(OP_UNUSED_HI)), CHAR_W'($urandom_range(255)),
                        IDX_W'($urandom_range(2 ** IDX_W - 1)));
    end
  endtask

  initial begin
    int p;
    int base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass under reset attributes
    push_console_op(OP_READ, 8'h00, 11'd0);
    push_console_op(OP_READ, 8'h00, IDX_W'(CELLS - 1));
    push_console_op(OP_READ, 8'h00, IDX_W'(CELLS));
    push_console_op(OP_READ, 8'hFF, 11'h7FF);
    push_console_op(OP_BACKSPACE, 8'h00, 11'd0);
    push_console_op(OP_PUT, 8'h00, 11'd0);
    push_console_op(OP_PUT, 8'hFF, 11'h7FF);
    push_console_op(OP_PUT, 8'h41, 11'd0);
    push_console_op(OP_BACKSPACE, 8'h00, 11'd0);
    push_console_op(OP_READ, 8'h00, 11'd0);
    push_console_op(OP_READ, 8'h00, 11'd1);
    push_console_op(OP_READ, 8'h00, 11'd2);
    push_console_op(OP_NEWLINE, 8'h00, 11'd0);
    push_console_op(OP_UNUSED_LO, 8'h00, 11'd0);
    push_console_op(OP_UNUSED_LO + 3'd1, 8'h55, 11'h2AA);
    push_console_op(OP_UNUSED_HI, 8'hFF, 11'h7FF);
    push_console_op(OP_PUT, 8'h7E, 11'd0);
    push_console_op(OP_READ, 8'h00, IDX_W'(COLUMNS));
    push_console_op(OP_CLEAR, 8'hFF, 11'h7FF);
    push_console_op(OP_READ, 8'h00, IDX_W'(COLUMNS));
    push_console_op(OP_READ, 8'h00, 11'd1);

    // Random phases, each under its own attribute setting and idling mix
    base = items_sent;
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       write_attributes(8'h00, 8'hFF);
        1:       write_attributes(8'hFF, 8'h00);
        2, 3:    write_attributes(ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)));
        default: write_attributes(RESET_ATTR, 8'h80);
      endcase
      case (p)
        0: begin
          gap_pct   = 25;
          stall_pct = 25;
        end
        1: begin
          gap_pct   = 60;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 60;
        end
        3: begin
          gap_pct   = 35;
          stall_pct = 35;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      while (items_sent < base + (p + 1) * RANDOM_ITEMS / PHASES) run_segment();
    end

    // Drain and give the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_text_console_writer_unit: done, clean");
    end else begin
      $display("tb_text_console_writer_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_seq.sv
rtl/core/text_console_writer_unit.sv
tb/sv/console_checker.sv
tb/sv/tb_text_console_writer_unit.sv
